/* design/fphd_pkg.sv */
// ============================================================================
// fphd_pkg: shared types and constants of the half-period dither core
// Widths of the word fields and the command and result structures used by the
// front end, back end and top, and the back end's sequencer state encoding.
// ============================================================================
package fphd_pkg;

    localparam int HZ_W        = 24;
    localparam int MHZ_W       = 11;
    localparam int CLOCK_W     = 29;
    localparam int DELAY_W     = 8;
    localparam int COUNT_W     = 8;
    localparam int INC_W       = 31;
    localparam int DEN_W       = 35;
    localparam int DEN_S_W     = DEN_W + 2;
    localparam int PROD_W      = 39;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = CLOCK_W;

    localparam int HZ_SCALE    = 2000;
    localparam int CLOCK_SCALE = 1000;

    localparam int FRACTION_BITS_DEFAULT = 24;
    localparam int QUEUE_DEPTH_DEFAULT   = 2;

    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = CLOCK_W'(125000000);

    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_HZ     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_CYCLES = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_FREQ   = 2'd1,
        OP_REJECT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_COUNT    = 2'd0,
        STATUS_FREQ_OK  = 2'd1,
        STATUS_FREQ_REJ = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [DEN_W-1:0] den;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        status_t            status;
    } res_t;

endpackage

/* design/fphd_queue.sv */
// ============================================================================
// fphd_queue: small first-in first-out queue
// Register-based queue with occupancy count; push is ignored while full and
// pop is ignored while empty.
// ============================================================================
module fphd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fphd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import fphd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/fphd_front.sv */
// ============================================================================
// fphd_front: input word classification
// Forms the divisor 2000*hz + 2*millihz and sorts each word into a tick, a
// usable frequency, or a frequency with a non-positive divisor.
// ============================================================================
module fphd_front (
    input  logic                      kind,
    input  logic [fphd_pkg::HZ_W-1:0] freq_hz,
    input  logic signed [fphd_pkg::MHZ_W-1:0] freq_millihz,
    output fphd_pkg::cmd_t            cmd
);
    import fphd_pkg::*;

    logic [DEN_S_W-1:0] hz_ext;
    logic [DEN_S_W-1:0] mhz_ext;
    logic [DEN_S_W-1:0] den_s;
    logic               den_positive;

    assign hz_ext  = {{(DEN_S_W - HZ_W){1'b0}}, freq_hz};
    assign mhz_ext = {{(DEN_S_W - MHZ_W){freq_millihz[MHZ_W-1]}}, freq_millihz};
    // Two's complement sum; the top bit is the sign of the divisor.
    assign den_s   = hz_ext * DEN_S_W'(HZ_SCALE) + (mhz_ext << 1);
    assign den_positive = !den_s[DEN_S_W-1] && (den_s != '0);

    always_comb
    begin
        cmd.den = den_s[DEN_W-1:0];
        if (kind)
        begin
            cmd.op = OP_TICK;
        end
        else if (den_positive)
        begin
            cmd.op = OP_FREQ;
        end
        else
        begin
            cmd.op = OP_REJECT;
        end
    end

endmodule

/* design/fphd_back.sv */
// ============================================================================
// fphd_back: command execution
// Runs the rounded restoring division for frequency words, one quotient bit
// per cycle, and the first-order error feedback for tick words.
// ============================================================================
module fphd_back #(
    parameter int FRACTION_BITS = fphd_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    input  fphd_pkg::cmd_t               cmd,
    output logic                         cmd_pop,
    input  logic [fphd_pkg::CLOCK_W-1:0] clock_hz,
    input  logic [fphd_pkg::DELAY_W-1:0] delay_cycles,
    input  logic                         res_ready,
    output logic                         res_push,
    output fphd_pkg::res_t               res
);
    import fphd_pkg::*;

    localparam int PE_W  = FRACTION_BITS + 1;
    localparam int XW    = (FRACTION_BITS + COUNT_W + 1 > INC_W + 2) ?
                           FRACTION_BITS + COUNT_W + 1 : INC_W + 2;
    localparam int SH    = INC_W - FRACTION_BITS;
    localparam int CNT_W = $clog2(INC_W);

    state_t             state_reg, state_next;
    logic [INC_W-1:0]   inc_reg, inc_next;
    logic [PE_W-1:0]    pe_reg, pe_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [INC_W-1:0]   div_low_reg, div_low_next;
    logic [INC_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ok_reg, ok_next;

    logic [XW-1:0]      x;
    logic [COUNT_W-1:0] tick_count;
    logic [PE_W-1:0]    tick_pe;
    logic               tick_fire;
    logic [PROD_W-1:0]  head;
    logic               overflow;
    logic [DEN_W:0]     trial;
    logic               trial_ge;
    logic               round_up;
    logic [INC_W:0]     quo_rounded;
    logic               round_ok;
    logic               cnt_last;

    // Tick: x = inc - err + half; the count is x >> F less the delay and the new error is
    // half minus the fraction bits of x.
    assign x = {{(XW - INC_W){1'b0}}, inc_reg}
             - {{(XW - PE_W){pe_reg[PE_W-1]}}, pe_reg}
             + (XW'(1) << (FRACTION_BITS - 1));
    assign tick_count = x[FRACTION_BITS +: COUNT_W] - delay_cycles;
    assign tick_pe    = (PE_W'(1) << (FRACTION_BITS - 1))
                      - {1'b0, x[FRACTION_BITS-1:0]};
    assign tick_fire  = (state_reg == ST_IDLE) && cmd_valid && (cmd.op == OP_TICK)
                      && res_ready;

    // The quotient fits in INC_W bits exactly when the dividend bits above
    // the lowest INC_W stay below the divisor.
    assign head     = prod_reg >> SH;
    assign overflow = (head >= {{(PROD_W - DEN_W){1'b0}}, den_reg});

    assign trial    = {rem_reg, div_low_reg[INC_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign cnt_last = (cnt_reg == CNT_W'(INC_W - 1));

    assign round_up    = (rem_reg >= (den_reg >> 1));
    assign quo_rounded = {1'b0, quo_reg} + {{INC_W{1'b0}}, round_up};
    assign round_ok    = (quo_rounded != '0) && !quo_rounded[INC_W];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_FREQ))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_CHECK;
            ST_CHECK: state_next = overflow ? ST_DONE : ST_DIV;
            ST_DIV:
            begin
                if (cnt_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: state_next = ST_DONE;
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res.count  = '0;
        res.status = STATUS_COUNT;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_TICK:
                        begin
                            cmd_pop   = res_ready;
                            res_push  = res_ready;
                            res.count = tick_count;
                        end
                        OP_REJECT:
                        begin
                            cmd_pop    = res_ready;
                            res_push   = res_ready;
                            res.status = STATUS_FREQ_REJ;
                        end
                        OP_FREQ: cmd_pop = 1'b1;
                        default: cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_DONE:
            begin
                res_push   = res_ready;
                res.status = ok_reg ? STATUS_FREQ_OK : STATUS_FREQ_REJ;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        inc_next     = inc_reg;
        pe_next      = pe_reg;
        den_next     = den_reg;
        prod_next    = prod_reg;
        rem_next     = rem_reg;
        div_low_next = div_low_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        ok_next      = ok_reg;
        if (tick_fire)
        begin
            pe_next = tick_pe;
        end
        case (state_reg)
            ST_IDLE:
            begin
                den_next = cmd.den;
            end
            ST_MUL:
            begin
                prod_next = {{(PROD_W - CLOCK_W){1'b0}}, clock_hz} * PROD_W'(CLOCK_SCALE);
            end
            ST_CHECK:
            begin
                rem_next     = head[DEN_W-1:0];
                div_low_next = prod_reg[INC_W-1:0] << FRACTION_BITS;
                quo_next     = '0;
                cnt_next     = '0;
                ok_next      = 1'b0;
            end
            ST_DIV:
            begin
                rem_next     = trial_ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quo_next     = {quo_reg[INC_W-2:0], trial_ge};
                div_low_next = div_low_reg << 1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_ROUND:
            begin
                ok_next = round_ok;
                if (round_ok)
                begin
                    inc_next = quo_rounded[INC_W-1:0];
                end
            end
            default:
            begin
                ok_next = ok_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            inc_reg   <= '0;
            pe_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            inc_reg   <= inc_next;
            pe_reg    <= pe_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg     <= den_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        div_low_reg <= div_low_next;
        quo_reg     <= quo_next;
        ok_reg      <= ok_next;
    end

endmodule

/* design/fractional_half_period_dither.sv */
// ============================================================================
// fractional_half_period_dither: half-period counter core of a numerically
// controlled oscillator
// Frequency words set the clock cycles per half period in fixed point by a
// rounded division; tick words return the next integer half-period count,
// dithered by first-order error feedback, less a fixed program delay.
// ============================================================================
//
//  Channel   Handshake              Fields
//  --------  ---------------------  ----------------------------------------
//  input     push / full            kind, freq_hz, freq_millihz
//  result    pop / empty            count, status
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick word is answered from idle. A frequency word runs through the restoring
// divider (pop, multiply, range check, 31 quotient bits, rounding, push); a
// divisor-sign reject is answered from idle and a quotient-overflow reject skips
// the division. Reset is asynchronous: increment and phase error clear, clock_hz
// returns to 125 MHz and delay_cycles to zero. The back end stalls only on a full
// result queue; full rises when the command queue fills.
//
module fractional_half_period_dither #(
    parameter int FRACTION_BITS = fphd_pkg::FRACTION_BITS_DEFAULT,
    parameter int QUEUE_DEPTH   = fphd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             kind,
    input  logic [fphd_pkg::HZ_W-1:0]        freq_hz,
    input  logic signed [fphd_pkg::MHZ_W-1:0] freq_millihz,
    output logic                             empty,
    input  logic                             pop,
    output logic [fphd_pkg::COUNT_W-1:0]     count,
    output logic [1:0]                       status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fphd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fphd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fphd_pkg::*;

    logic [CLOCK_W-1:0] clock_hz_reg, clock_hz_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;

    cmd_t in_cmd;
    cmd_t q_cmd;
    logic cmd_empty;
    logic cmd_pop;
    res_t back_res;
    res_t out_res;
    logic res_full;
    logic res_push;

    // Configuration is always ready; writes to an index past the register
    // list are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        clock_hz_next = clock_hz_reg;
        delay_next    = delay_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLOCK_HZ:     clock_hz_next = cfg_data[CLOCK_W-1:0];
                REG_DELAY_CYCLES: delay_next    = cfg_data[DELAY_W-1:0];
                default:          delay_next    = delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            delay_reg    <= '0;
        end
        else
        begin
            clock_hz_reg <= clock_hz_next;
            delay_reg    <= delay_next;
        end
    end

    // The front end classifies each word as it enters the command queue.
    fphd_front u_front (
        .kind         (kind),
        .freq_hz      (freq_hz),
        .freq_millihz (freq_millihz),
        .cmd          (in_cmd)
    );

    fphd_queue #(
        .WIDTH (DEN_W + 2),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_cmd),
        .full      (full),
        .pop       (cmd_pop),
        .pop_data  (q_cmd),
        .empty     (cmd_empty)
    );

    // The back end executes commands in order and stalls on a full result
    // queue; the command queue keeps taking words meanwhile until it fills.
    fphd_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!cmd_empty),
        .cmd          (q_cmd),
        .cmd_pop      (cmd_pop),
        .clock_hz     (clock_hz_reg),
        .delay_cycles (delay_reg),
        .res_ready    (!res_full),
        .res_push     (res_push),
        .res          (back_res)
    );

    fphd_queue #(
        .WIDTH (COUNT_W + 2),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (back_res),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (out_res),
        .empty     (empty)
    );

    assign count  = out_res.count;
    assign status = out_res.status;

endmodule

/* test/fractional_half_period_dither_tb.sv */
// ----------------------------------------------------------------------------
// fractional_half_period_dither_tb: self-checking bench of the dither core
// Frequency and tick words go in through the push/full queue and results come
// back through pop/empty. A behavioral copy of the divider and of the error
// feedback loop predicts every result, which is compared field by field.
// ----------------------------------------------------------------------------
module fractional_half_period_dither_tb;

    import fphd_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEFAULT;
    localparam longint unsigned INC_LIMIT = 64'h7FFF_FFFF;
    localparam logic KIND_FREQ = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic [HZ_W-1:0] HZ_MAX = '1;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   push         = 1'b0;
    logic                   full;
    logic                   kind         = KIND_TICK;
    logic [HZ_W-1:0]        freq_hz      = '0;
    logic signed [MHZ_W-1:0] freq_millihz = '0;
    logic                   empty;
    logic                   pop          = 1'b0;
    logic [COUNT_W-1:0]     count;
    logic [1:0]             status;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // Shadow copy of the oscillator: registers, increment and phase error.
    logic [CLOCK_W-1:0]     dco_clock_hz;
    logic [DELAY_W-1:0]     dco_delay;
    logic [INC_W-1:0]       dco_increment;
    longint                 dco_phase_error;

    // Results predicted for accepted words, oldest first.
    res_t                   awaited_results[$];
    int unsigned            mismatch_count = 0;

    // When set, neither side inserts idle cycles.
    bit                     steady = 1'b0;

    fractional_half_period_dither #(
        .FRACTION_BITS(FRAC)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .freq_hz     (freq_hz),
        .freq_millihz(freq_millihz),
        .empty       (empty),
        .pop         (pop),
        .count       (count),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Generous bound: the slowest legal run is well under a tenth of this.
    initial
    begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Predict the result of one word and advance the shadow state. A frequency
    // word computes round(clock_hz * 1000 * 2^FRAC / (2000*hz + 2*mhz)); the
    // full-width quotient is taken at once, which rejects exactly the same
    // words as a bit-serial divider that stops on overflow, since every
    // partial quotient is a prefix of the final one.
    function automatic res_t predict_half_period(logic k, logic [HZ_W-1:0] hz,
                                                 logic signed [MHZ_W-1:0] mhz);
        res_t                   r;
        longint                 den;
        longint unsigned        num;
        longint unsigned        quo;
        longint unsigned        rem;
        longint                 x;
        longint                 whole;
        if (k == KIND_FREQ)
        begin
            r.count  = '0;
            r.status = STATUS_FREQ_REJ;
            den = 2000 * longint'(hz) + 2 * longint'(mhz);
            if (den > 0)
            begin
                num = (longint'(dco_clock_hz) * 1000) << FRAC;
                quo = num / longint'(den);
                rem = num % longint'(den);
                if (rem >= (longint'(den) >> 1))
                    quo = quo + 1;
                // Only the increment changes; the phase error carries over.
                if (quo != 0 && quo <= INC_LIMIT)
                begin
                    dco_increment = quo[INC_W-1:0];
                    r.status      = STATUS_FREQ_OK;
                end
            end
        end
        else
        begin
            // Round the increment less the running error to whole cycles,
            // then feed the rounding error back for the next half period.
            x = longint'(dco_increment) - dco_phase_error + (longint'(1) << (FRAC - 1));
            whole = x >>> FRAC;
            dco_phase_error = dco_phase_error + (whole <<< FRAC) - longint'(dco_increment);
            r.count  = COUNT_W'(whole - longint'(dco_delay));
            r.status = STATUS_COUNT;
        end
        return r;
    endfunction

    // Result side: random pop stalls in bursts unless steady is set.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!steady && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    // Every word that leaves the block is matched against the oldest
    // prediction.
    always @(posedge clk)
    begin
        res_t exp_res;
        if (rst_n && pop && !empty)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result word: expected none, got count %0d status %0d",
                         $time, count, status);
            end
            else
            begin
                exp_res = awaited_results.pop_front();
                if (count !== exp_res.count)
                begin
                    mismatch_count++;
                    $display("%0t: count mismatch: expected %0d, got %0d",
                             $time, exp_res.count, count);
                end
                if (status !== exp_res.status)
                begin
                    mismatch_count++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, exp_res.status, status);
                end
            end
        end
    end

    // Present one word and hold it until the block takes it. Push stays high
    // on return unless an idle burst follows, so back-to-back words need no
    // idle gap between them.
    task automatic send_word(logic k, logic [HZ_W-1:0] hz, logic signed [MHZ_W-1:0] mhz);
        push         <= 1'b1;
        kind         <= k;
        freq_hz      <= hz;
        freq_millihz <= mhz;
        do
            @(posedge clk);
        while (full);
        awaited_results.push_back(predict_half_period(k, hz, mhz));
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    // Idle point for register writes: results drained, plus the longest
    // frequency computation so nothing is still in flight.
    task automatic wait_idle();
        drain_results();
        repeat (48) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_CLOCK_HZ)
            dco_clock_hz = data;
        else if (idx == REG_DELAY_CYCLES)
            dco_delay = data[DELAY_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Right after reset the increment is zero, so every tick yields a zero
    // count less the delay. Tick words carry arbitrary frequency fields that
    // must be ignored.
    task automatic test_ticks_before_frequency();
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_TICK, HZ_MAX, -11'sd1);
        wait_idle();
        // All data bits set: the delay becomes 255 from the low byte.
        write_register(REG_DELAY_CYCLES, '1);
        send_word(KIND_TICK, 24'h5A5A5A, 11'sh2A5);
        wait_idle();
        write_register(REG_DELAY_CYCLES, '0);
    endtask

    // Divisor sign, quotient overflow and zero quotient, each at its edge,
    // at the reset clock and at both clock extremes.
    task automatic test_frequency_limits();
        send_word(KIND_FREQ, '0, '0);           // zero divisor
        send_word(KIND_FREQ, '0, -11'sd1);      // negative divisor
        send_word(KIND_FREQ, '0, -11'sd1024);   // most negative offset
        send_word(KIND_FREQ, '0, 11'sd1);       // tiny divisor, huge quotient
        send_word(KIND_FREQ, 24'd488281, '0);   // quotient just past INC_W bits
        send_word(KIND_FREQ, 24'd488282, '0);   // quotient just within INC_W bits
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_TICK, '0, '0);
        // Phase error from the previous setting carries into this one.
        send_word(KIND_FREQ, 24'd1000000, '0);
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_FREQ, HZ_MAX, 11'sd1023);
        send_word(KIND_TICK, '0, '0);
        wait_idle();
        write_register(REG_CLOCK_HZ, 29'd1);
        // The quotient rounds to zero with the largest divisor and to one
        // with the offset at its most negative.
        send_word(KIND_FREQ, HZ_MAX, 11'sd1023);
        send_word(KIND_FREQ, HZ_MAX, -11'sd1024);
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_TICK, '0, '0);
        wait_idle();
        write_register(REG_CLOCK_HZ, '1);
        write_register(REG_DELAY_CYCLES, 29'd255);
        send_word(KIND_FREQ, HZ_MAX, 11'sd1023);
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_TICK, '0, '0);
    endtask

    // One random phase under one register setting. Most frequency words fall
    // in a band derived from the clock setting in which the quotient fits in INC_W
    // bits, so ticks produce varied counts; the rest are random and mostly rejected.
    task automatic run_random_phase(int unsigned n_items, logic [CLOCK_W-1:0] clock_setting,
                                    logic [DELAY_W-1:0] delay_setting);
        int unsigned            lo;
        int unsigned            hi;
        logic [CFG_DATA_W-1:0]  data;
        logic [HZ_W-1:0]        hz;
        logic signed [MHZ_W-1:0] mhz;
        wait_idle();
        write_register(REG_CLOCK_HZ, clock_setting);
        data = CFG_DATA_W'($urandom);
        data[DELAY_W-1:0] = delay_setting;
        write_register(REG_DELAY_CYCLES, data);
        // Indexes past the last register are ignored by the block.
        write_register(CFG_INDEX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
        lo = dco_clock_hz / 256 + 1;
        hi = (lo * 256 > HZ_MAX) ? HZ_MAX : lo * 256;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                drain_results();
            if ($urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    hz  = HZ_W'($urandom);
                    mhz = MHZ_W'($urandom);
                end
                else
                begin
                    hz  = HZ_W'($urandom_range(lo, hi));
                    mhz = MHZ_W'(int'($urandom_range(0, 1998)) - 999);
                end
                send_word(KIND_FREQ, hz, mhz);
            end
            else
            begin
                send_word(KIND_TICK, HZ_W'($urandom), MHZ_W'($urandom));
            end
        end
    endtask

    initial
    begin
        dco_clock_hz    = CLOCK_HZ_RESET;
        dco_delay       = '0;
        dco_increment   = '0;
        dco_phase_error = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ticks_before_frequency();
        test_frequency_limits();

        run_random_phase(500, CLOCK_HZ_RESET, 8'd0);
        run_random_phase(400, '1, 8'd255);
        run_random_phase(300, 29'd1, DELAY_W'($urandom));
        run_random_phase(400, CLOCK_W'($urandom_range(1, 300000000)), DELAY_W'($urandom));

        // Last stretch at full rate on both sides.
        steady = 1'b1;
        run_random_phase(350, CLOCK_HZ_RESET, DELAY_W'($urandom));

        wait_idle();
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
